>>> sv/assert_macros.svh
// Assertion macros for the files that check their own logic.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define OGN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("octave noise assertion failed");

// Checked on every rising edge, reset included.
`define OGN_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("octave noise assertion failed");

`endif

>>> sv/ogn2d_pkg.sv
// Shared constants, command types, micro-step table and gradient function
// of the octave gradient noise block. Depends on nothing.
package ogn2d_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 8;
    localparam int QUO_W       = 17;
    localparam int STEP_W      = 4;

    localparam logic [3:0]  OCTAVES_RESET     = 4'd4;
    localparam logic [15:0] PERSISTENCE_RESET = 16'd32768;

    localparam logic CFG_OCTAVES     = 1'b0;
    localparam logic CFG_PERSISTENCE = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] RD_NONE = 3'd0;
    localparam logic [2:0] RD_XI   = 3'd1;
    localparam logic [2:0] RD_XI1  = 3'd2;
    localparam logic [2:0] RD_AA   = 3'd3;
    localparam logic [2:0] RD_AB   = 3'd4;
    localparam logic [2:0] RD_BA   = 3'd5;
    localparam logic [2:0] RD_BB   = 3'd6;

    localparam logic [3:0] MU_NONE = 4'd0;
    localparam logic [3:0] MU_TX2  = 4'd1;
    localparam logic [3:0] MU_INX  = 4'd2;
    localparam logic [3:0] MU_T3X  = 4'd3;
    localparam logic [3:0] MU_TY2  = 4'd4;
    localparam logic [3:0] MU_FDX  = 4'd5;
    localparam logic [3:0] MU_INY  = 4'd6;
    localparam logic [3:0] MU_T3Y  = 4'd7;
    localparam logic [3:0] MU_L1   = 4'd8;
    localparam logic [3:0] MU_L2   = 4'd9;
    localparam logic [3:0] MU_FDY  = 4'd10;
    localparam logic [3:0] MU_L3   = 4'd11;
    localparam logic [3:0] MU_ACC  = 4'd12;
    localparam logic [3:0] MU_AMP  = 4'd13;

    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_T2X  = 4'd1;
    localparam logic [3:0] WB_INX  = 4'd2;
    localparam logic [3:0] WB_T3X  = 4'd3;
    localparam logic [3:0] WB_T2Y  = 4'd4;
    localparam logic [3:0] WB_U    = 4'd5;
    localparam logic [3:0] WB_INY  = 4'd6;
    localparam logic [3:0] WB_T3Y  = 4'd7;
    localparam logic [3:0] WB_R1   = 4'd8;
    localparam logic [3:0] WB_R2   = 4'd9;
    localparam logic [3:0] WB_V    = 4'd10;
    localparam logic [3:0] WB_N    = 4'd11;
    localparam logic [3:0] WB_ACC  = 4'd12;
    localparam logic [3:0] WB_AMP  = 4'd13;

    typedef struct packed {
        logic [2:0] rd;
        logic [3:0] mul;
        logic [3:0] wb;
    } t_step;

    typedef struct packed {
        logic  start;
        logic  load;
        t_step step;
        logic  div_init;
        logic  div_step;
        logic  out_load;
    } t_ctl;

    // One octave takes sixteen steps through the shared multiplier and table port.
    function automatic t_step step_cmd(input logic [STEP_W-1:0] s);
        t_step c;
        c = '{rd: RD_NONE, mul: MU_NONE, wb: WB_NONE};
        case (s)
            4'd0:  c = '{rd: RD_XI,   mul: MU_TX2,  wb: WB_NONE};
            4'd1:  c = '{rd: RD_XI1,  mul: MU_INX,  wb: WB_T2X};
            4'd2:  c = '{rd: RD_AA,   mul: MU_T3X,  wb: WB_INX};
            4'd3:  c = '{rd: RD_AB,   mul: MU_TY2,  wb: WB_T3X};
            4'd4:  c = '{rd: RD_BA,   mul: MU_FDX,  wb: WB_T2Y};
            4'd5:  c = '{rd: RD_BB,   mul: MU_INY,  wb: WB_U};
            4'd6:  c = '{rd: RD_NONE, mul: MU_T3Y,  wb: WB_INY};
            4'd7:  c = '{rd: RD_NONE, mul: MU_L1,   wb: WB_T3Y};
            4'd8:  c = '{rd: RD_NONE, mul: MU_L2,   wb: WB_R1};
            4'd9:  c = '{rd: RD_NONE, mul: MU_FDY,  wb: WB_R2};
            4'd10: c = '{rd: RD_NONE, mul: MU_NONE, wb: WB_V};
            4'd11: c = '{rd: RD_NONE, mul: MU_L3,   wb: WB_NONE};
            4'd12: c = '{rd: RD_NONE, mul: MU_NONE, wb: WB_N};
            4'd13: c = '{rd: RD_NONE, mul: MU_ACC,  wb: WB_NONE};
            4'd14: c = '{rd: RD_NONE, mul: MU_AMP,  wb: WB_ACC};
            4'd15: c = '{rd: RD_NONE, mul: MU_NONE, wb: WB_AMP};
            default: c = '{rd: RD_NONE, mul: MU_NONE, wb: WB_NONE};
        endcase
        return c;
    endfunction

    function automatic logic signed [19:0] grad(input logic [1:0] h,
                                                input logic signed [17:0] gx,
                                                input logic signed [17:0] gy);
        logic signed [19:0] a;
        logic signed [19:0] b;
        a = h[1] ? 20'(gy) : 20'(gx);
        b = h[1] ? 20'(gx) : 20'(gy);
        if (h[0]) begin
            a = -a;
        end
        if (h[1]) begin
            b = -b;
        end
        return a + b;
    endfunction

endpackage

>>> sv/ogn2d_ctrl.sv
// Sequencer of the octave gradient noise block: handshakes, octave and step
// counters, divider counter. Depends on ogn2d_pkg.
module ogn2d_ctrl #(
    parameter int MAX_OCTAVES = ogn2d_pkg::MAX_OCTAVES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_opcode,
    input  logic [3:0]         i_octave_count,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ogn2d_pkg::t_ctl    o_ctl
);

    localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OCT  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [ogn2d_pkg::STEP_W-1:0]   r_step, n_step;
    logic [OCT_W-1:0]               r_oct, n_oct;
    logic [OCT_W-1:0]               r_last, n_last;
    logic [4:0]                     r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    logic [3:0]                     count_c;
    logic                           accept;
    logic                           out_free;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_octave_count == 4'd0) begin
            count_c = 4'd1;
        end else if (i_octave_count > 4'(MAX_OCTAVES)) begin
            count_c = 4'(MAX_OCTAVES);
        end else begin
            count_c = i_octave_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_oct   = r_oct;
        n_last  = r_last;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.start = accept && (i_opcode == ogn2d_pkg::OP_EVAL);
                o_ctl.load  = accept && (i_opcode == ogn2d_pkg::OP_LOAD);
                if (accept && (i_opcode == ogn2d_pkg::OP_EVAL)) begin
                    n_state = ST_OCT;
                    n_step  = '0;
                    n_oct   = '0;
                    n_last  = OCT_W'(count_c - 4'd1);
                end
            end
            ST_OCT: begin
                o_ctl.step = ogn2d_pkg::step_cmd(r_step);
                n_step     = r_step + 1'b1;
                if (r_step == '1) begin
                    n_oct = r_oct + 1'b1;
                    if (r_oct == r_last) begin
                        n_state = ST_DIV;
                        n_cnt   = '0;
                    end
                end
            end
            ST_DIV: begin
                o_ctl.div_init = (r_cnt == 5'd0);
                o_ctl.div_step = (r_cnt != 5'd0);
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'(ogn2d_pkg::QUO_W)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_ctl.out_load = out_free;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_oct       <= '0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_oct       <= n_oct;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/ogn2d_dp.sv
// Datapath of the octave gradient noise block: permutation table, shared
// multiplier, fade and blend registers, accumulators and serial divider.
// Depends on ogn2d_pkg.
module ogn2d_dp #(
    parameter int MAX_OCTAVES = ogn2d_pkg::MAX_OCTAVES
) (
    input  logic              i_clk,
    input  ogn2d_pkg::t_ctl   i_ctl,
    input  logic [7:0]        i_table_index,
    input  logic [7:0]        i_table_value,
    input  logic [23:0]       i_x_coord,
    input  logic [23:0]       i_y_coord,
    input  logic [15:0]       i_persistence,
    output logic [15:0]       o_noise_value
);

    localparam int LOG_OCT = $clog2(MAX_OCTAVES);
    localparam int TOT_W   = 33 + LOG_OCT;
    localparam int WGT_W   = 17 + LOG_OCT;
    localparam int QW      = ogn2d_pkg::QUO_W;

    logic [7:0]          r_mem [0:ogn2d_pkg::TABLE_SIZE-1];
    logic [7:0]          r_rdata;
    logic [2:0]          r_rd_prev;
    logic [7:0]          rd_addr;

    logic [23:0]         r_xs, r_ys;
    logic [7:0]          r_pa, r_pb;
    logic [1:0]          r_haa, r_hab, r_hba, r_hbb;
    logic [15:0]         r_t2x, r_t3x, r_t2y, r_t3y;
    logic [19:0]         r_inx, r_iny;
    logic [16:0]         r_u, r_v;
    logic signed [20:0]  r_r1, r_r2;
    logic [16:0]         r_val;
    logic [16:0]         r_amp;
    logic [TOT_W-1:0]    r_total;
    logic [WGT_W-1:0]    r_weight;
    logic [WGT_W-1:0]    r_rem;
    logic [QW-1:0]       r_dsh;
    logic [QW-1:0]       r_quo;
    logic [15:0]         r_noise;
    logic signed [49:0]  r_prod;

    logic [15:0]         tx, ty;
    logic [7:0]          xi, yi;
    logic [20:0]         kx, ky;
    logic signed [17:0]  xf, yf, xf1, yf1;
    logic signed [19:0]  g_aa, g_ab, g_ba, g_bb;
    logic signed [24:0]  op_a, op_b;
    logic signed [49:0]  prod_sh;
    logic signed [20:0]  n_sum;
    logic signed [21:0]  m_sum;
    logic [16:0]         val_c;
    logic [WGT_W:0]      trial;
    logic                ge;

    assign tx  = r_xs[15:0];
    assign ty  = r_ys[15:0];
    assign xi  = r_xs[23:16];
    assign yi  = r_ys[23:16];
    assign kx  = 21'(15 * ogn2d_pkg::ONE) - 21'({tx, 2'b00}) - 21'({tx, 1'b0});
    assign ky  = 21'(15 * ogn2d_pkg::ONE) - 21'({ty, 2'b00}) - 21'({ty, 1'b0});
    assign xf  = {2'b00, tx};
    assign yf  = {2'b00, ty};
    assign xf1 = xf - 18'(ogn2d_pkg::ONE);
    assign yf1 = yf - 18'(ogn2d_pkg::ONE);

    assign g_aa = ogn2d_pkg::grad(r_haa, xf, yf);
    assign g_ba = ogn2d_pkg::grad(r_hba, xf1, yf);
    assign g_ab = ogn2d_pkg::grad(r_hab, xf, yf1);
    assign g_bb = ogn2d_pkg::grad(r_hbb, xf1, yf1);

    always_comb begin
        case (i_ctl.step.rd)
            ogn2d_pkg::RD_XI:  rd_addr = xi;
            ogn2d_pkg::RD_XI1: rd_addr = xi + 8'd1;
            ogn2d_pkg::RD_AA:  rd_addr = r_pa + yi;
            ogn2d_pkg::RD_AB:  rd_addr = r_pa + yi + 8'd1;
            ogn2d_pkg::RD_BA:  rd_addr = r_pb + yi;
            ogn2d_pkg::RD_BB:  rd_addr = r_pb + yi + 8'd1;
            default:           rd_addr = xi;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mem[i_table_index] <= i_table_value;
        end
        r_rdata   <= r_mem[rd_addr];
        r_rd_prev <= i_ctl.step.rd;
    end

    always_ff @(posedge i_clk) begin
        case (r_rd_prev)
            ogn2d_pkg::RD_XI:  r_pa  <= r_rdata;
            ogn2d_pkg::RD_XI1: r_pb  <= r_rdata;
            ogn2d_pkg::RD_AA:  r_haa <= r_rdata[1:0];
            ogn2d_pkg::RD_AB:  r_hab <= r_rdata[1:0];
            ogn2d_pkg::RD_BA:  r_hba <= r_rdata[1:0];
            ogn2d_pkg::RD_BB:  r_hbb <= r_rdata[1:0];
            default: begin
            end
        endcase
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_ctl.step.mul)
            ogn2d_pkg::MU_TX2: begin
                op_a = {9'd0, tx};
                op_b = {9'd0, tx};
            end
            ogn2d_pkg::MU_INX: begin
                op_a = {9'd0, tx};
                op_b = {4'd0, kx};
            end
            ogn2d_pkg::MU_T3X: begin
                op_a = {9'd0, r_t2x};
                op_b = {9'd0, tx};
            end
            ogn2d_pkg::MU_FDX: begin
                op_a = {9'd0, r_t3x};
                op_b = {5'd0, r_inx};
            end
            ogn2d_pkg::MU_TY2: begin
                op_a = {9'd0, ty};
                op_b = {9'd0, ty};
            end
            ogn2d_pkg::MU_INY: begin
                op_a = {9'd0, ty};
                op_b = {4'd0, ky};
            end
            ogn2d_pkg::MU_T3Y: begin
                op_a = {9'd0, r_t2y};
                op_b = {9'd0, ty};
            end
            ogn2d_pkg::MU_FDY: begin
                op_a = {9'd0, r_t3y};
                op_b = {5'd0, r_iny};
            end
            ogn2d_pkg::MU_L1: begin
                op_a = {8'd0, r_u};
                op_b = 25'(g_ba) - 25'(g_aa);
            end
            ogn2d_pkg::MU_L2: begin
                op_a = {8'd0, r_u};
                op_b = 25'(g_bb) - 25'(g_ab);
            end
            ogn2d_pkg::MU_L3: begin
                op_a = {8'd0, r_v};
                op_b = 25'(r_r2) - 25'(r_r1);
            end
            ogn2d_pkg::MU_ACC: begin
                op_a = {8'd0, r_val};
                op_b = {8'd0, r_amp};
            end
            ogn2d_pkg::MU_AMP: begin
                op_a = {8'd0, r_amp};
                op_b = {9'd0, i_persistence};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    assign prod_sh = r_prod >>> ogn2d_pkg::FRAC_BITS;
    assign n_sum   = r_r1 + signed'(prod_sh[20:0]);
    assign m_sum   = 22'(n_sum) + 22'(ogn2d_pkg::ONE);

    always_comb begin
        if (m_sum[21]) begin
            val_c = '0;
        end else if (m_sum[20:1] > 20'(ogn2d_pkg::ONE)) begin
            val_c = 17'(ogn2d_pkg::ONE);
        end else begin
            val_c = m_sum[17:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_xs     <= i_x_coord;
            r_ys     <= i_y_coord;
            r_amp    <= 17'(ogn2d_pkg::ONE);
            r_total  <= '0;
            r_weight <= '0;
        end
        case (i_ctl.step.wb)
            ogn2d_pkg::WB_T2X: r_t2x <= prod_sh[15:0];
            ogn2d_pkg::WB_INX: r_inx <= 20'(10 * ogn2d_pkg::ONE) - prod_sh[19:0];
            ogn2d_pkg::WB_T3X: r_t3x <= prod_sh[15:0];
            ogn2d_pkg::WB_U:   r_u   <= prod_sh[16:0];
            ogn2d_pkg::WB_T2Y: r_t2y <= prod_sh[15:0];
            ogn2d_pkg::WB_INY: r_iny <= 20'(10 * ogn2d_pkg::ONE) - prod_sh[19:0];
            ogn2d_pkg::WB_T3Y: r_t3y <= prod_sh[15:0];
            ogn2d_pkg::WB_V:   r_v   <= prod_sh[16:0];
            ogn2d_pkg::WB_R1:  r_r1  <= {g_aa[19], g_aa} + signed'(prod_sh[20:0]);
            ogn2d_pkg::WB_R2:  r_r2  <= {g_ab[19], g_ab} + signed'(prod_sh[20:0]);
            ogn2d_pkg::WB_N:   r_val <= val_c;
            ogn2d_pkg::WB_ACC: begin
                r_total  <= r_total + TOT_W'(r_prod[32:0]);
                r_weight <= r_weight + WGT_W'(r_amp);
            end
            ogn2d_pkg::WB_AMP: begin
                r_amp <= prod_sh[16:0];
                r_xs  <= {r_xs[22:0], 1'b0};
                r_ys  <= {r_ys[22:0], 1'b0};
            end
            default: begin
            end
        endcase
    end

    assign trial = {r_rem, r_dsh[QW-1]};
    assign ge    = (trial >= {1'b0, r_weight});

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_rem <= WGT_W'(r_total[TOT_W-1:QW]);
            r_dsh <= r_total[QW-1:0];
        end else if (i_ctl.div_step) begin
            r_rem <= ge ? WGT_W'(trial - {1'b0, r_weight}) : WGT_W'(trial);
            r_dsh <= {r_dsh[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], ge};
        end
        if (i_ctl.out_load) begin
            r_noise <= r_quo[QW-1] ? 16'hFFFF : r_quo[15:0];
        end
    end

    assign o_noise_value = r_noise;

endmodule

>>> sv/octave_gradient_noise_2d.sv
// Top level of the two-dimensional octave gradient noise block: configuration
// registers, sequencer and datapath. Depends on ogn2d_pkg, ogn2d_ctrl, ogn2d_dp.
//
//  Channel  Direction  Handshake               Payload
//  in       input      i_in_valid/o_in_stall   opcode, table index/value, x, y
//  out      output     o_out_valid/i_out_stall noise_value
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An evaluate beat steps through each octave, paced by the single shared
// multiplier and the single table read port, then runs a one-bit-a-cycle
// division and loads the output register once that register is free.
// Reset is synchronous and active low; the table is not cleared.
// A waiting result does not block the next beat; a finished evaluation
// holds until the output register is free.
`include "assert_macros.svh"

module octave_gradient_noise_2d #(
    parameter int MAX_OCTAVES = ogn2d_pkg::MAX_OCTAVES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_table_index,
    input  logic [7:0]  i_table_value,
    input  logic [23:0] i_x_coord,
    input  logic [23:0] i_y_coord,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_noise_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [3:0]       r_octave_count;
    logic [15:0]      r_persistence;
    ogn2d_pkg::t_ctl  ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= ogn2d_pkg::OCTAVES_RESET;
            r_persistence  <= ogn2d_pkg::PERSISTENCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ogn2d_pkg::CFG_OCTAVES:     r_octave_count <= i_cfg_data[3:0];
                ogn2d_pkg::CFG_PERSISTENCE: r_persistence  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ogn2d_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_opcode       (i_opcode),
        .i_octave_count (r_octave_count),
        .i_out_stall    (i_out_stall),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_ctl          (ctl)
    );

    ogn2d_dp #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_persistence  (r_persistence),
        .o_noise_value  (o_noise_value)
    );

    `OGN_ASSERT(a_eval_busy, i_in_valid && !o_in_stall && i_opcode |=> o_in_stall)
    `OGN_ASSERT(a_result_after_work, $rose(o_out_valid) |-> $past(o_in_stall))
    `OGN_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid)

endmodule
